// ===== src/fqr_pkg.sv =====
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and codes for the FIFO queue with remove-by-value.
// ----------------------------------------------------------------------------
package fqr_pkg;

    localparam int unsigned FQR_DEPTH      = 16;
    localparam int unsigned FQR_DATA_WIDTH = 32;

    // Action codes carried on the input tuser.
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic pop_do;     // drop the head: every cell takes its neighbor's data
        logic remove_do;  // search for the value and close the gap behind it
    } t_cell_ctrl;

endpackage

// ===== src/fqr_cell.sv =====
// ----------------------------------------------------------------------------
// fqr_cell
// One queue entry. Compares its word, passes the first-match flag down the
// chain, and takes its neighbor's word when the chain closes a gap.
// ----------------------------------------------------------------------------
module fqr_cell #(
    parameter int unsigned DATA_WIDTH = fqr_pkg::FQR_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  fqr_pkg::t_cell_ctrl   i_ctrl,
    input  logic                  i_occupied,
    input  logic                  i_load,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic                  i_hit,
    output logic                  o_hit,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic [DATA_WIDTH-1:0] o_data
);
    import fqr_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_match;
    logic                  w_shift;

    assign w_match = i_ctrl.remove_do && i_occupied && (r_data == i_value);
    assign o_hit   = i_hit || w_match;

    // Every cell at or behind the first match moves one place toward the head.
    assign w_shift = i_ctrl.pop_do || (i_ctrl.remove_do && o_hit);

    always_comb begin
        n_data = r_data;
        if (w_shift) begin
            n_data = i_next_data;
        end else if (i_load) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/fifo_queue_with_remove.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_remove
// Bounded FIFO of data words with push, pop, remove-first-match and clear,
// built as a compacting chain of entry cells. One result per action.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields
//  s_axis    in         tuser: action[1:0]; tdata: item_value[31:0]
//  m_axis    out        tdata: front_value[31:0], is_empty[32],
//                              entry_count[37:33], status[39:38]
//
// The match flag ripples through the cell chain and all cells update at
// the same edge, so one transfer per cycle is sustained while results are
// drained. The result sits in an output slot, and a new input is
// taken whenever that slot is empty or being drained in the same cycle.
// Synchronous active-low reset empties the queue and the output slot.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove #(
    parameter int unsigned DEPTH      = fqr_pkg::FQR_DEPTH,
    parameter int unsigned DATA_WIDTH = fqr_pkg::FQR_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // item_value[31:0]
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // front_value, is_empty, entry_count, status
);
    import fqr_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic                  r_out_valid;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;
    logic [1:0]            w_action;
    logic [DATA_WIDTH+31:0] w_val_ext;
    logic [DATA_WIDTH-1:0] w_value;
    t_cell_ctrl            w_ctrl;
    logic                  w_push_do;

    logic [DEPTH:0]        w_hit;
    logic [DATA_WIDTH-1:0] w_data [DEPTH+1];
    logic [DATA_WIDTH+31:0] w_front_ext;
    logic [CW+4:0]         w_count_ext;
    logic [31:0]           w_front;

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_action  = i_s_tuser;
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_empty   = (r_count == '0);

    // Only the low DATA_WIDTH bits of the value are stored and compared.
    assign w_val_ext = {{DATA_WIDTH{1'b0}}, i_s_tdata};
    assign w_value   = w_val_ext[DATA_WIDTH-1:0];

    assign w_push_do        = w_accept && (w_action == ACT_PUSH) && !w_full;
    assign w_ctrl.pop_do    = w_accept && (w_action == ACT_POP) && !w_empty;
    assign w_ctrl.remove_do = w_accept && (w_action == ACT_REMOVE);

    assign w_hit[0]     = 1'b0;
    assign w_data[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fqr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occupied  (CW'(g) < r_count),
            .i_load      (w_push_do && (CW'(g) == r_count)),
            .i_value     (w_value),
            .i_hit       (w_hit[g]),
            .o_hit       (w_hit[g+1]),
            .i_next_data (w_data[g+1]),
            .o_data      (w_data[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        case (w_action)
            ACT_PUSH: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_REMOVE: begin
                if (w_hit[DEPTH]) begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_status    <= STAT_OK;
        end else begin
            if (w_accept) begin
                r_count  <= n_count;
                r_status <= n_status;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The queue state only changes on an accepted transfer, which cannot happen
    // while a result is stalled, so the result is read straight from the cells.
    assign w_front_ext = {32'd0, w_data[0]};
    assign w_front     = w_empty ? 32'd0 : w_front_ext[31:0];
    assign w_count_ext = {5'd0, r_count};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_status, w_count_ext[4:0], w_empty, w_front};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_POP && !w_empty) |=>
            (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not drop one entry");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_CLEAR) |=> (r_count == '0 && r_status == STAT_OK))
        else $error("clear left entries");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_PUSH && w_full) |=>
            ($stable(r_count) && r_status == STAT_FULL))
        else $error("push on full queue changed the count");

endmodule
